/* hdl/rlpi_pkg.sv */
// Shared types and constants for the rate-limited pose integrator.
// Holds the controller/datapath command and status structs and the CORDIC angle table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rlpi_pkg;

	localparam int CNT_W = 6;

	localparam logic [9:0]  RST_SUBSTEPS   = 10'd100;
	localparam logic [31:0] RST_STEP_TIME  = 32'd1431655;
	localparam logic [30:0] RST_MAX_TURN   = 31'd33554432;
	localparam logic [30:0] RST_TURN_STEP  = 31'd2796;
	localparam logic [30:0] RST_MAX_SPEED  = 31'd655360;
	localparam logic [30:0] RST_SPEED_STEP = 31'd44;

	localparam logic signed [33:0] CORDIC_INIT = 34'sd652032875;
	localparam logic signed [49:0] POS_MAX = 50'sd140737488355327;
	localparam logic signed [49:0] POS_MIN = -50'sd140737488355328;

	typedef enum logic [2:0] {
		REG_SUBSTEPS,
		REG_STEP_TIME,
		REG_MAX_TURN,
		REG_TURN_STEP,
		REG_MAX_SPEED,
		REG_SPEED_STEP
	} cfg_reg_t;

	typedef enum logic [3:0] {
		MS_NONE,
		MS_VX_C,
		MS_VY_S,
		MS_VX_S,
		MS_VY_C,
		MS_AA,
		MS_BB,
		MS_LL,
		MS_AL,
		MS_BL,
		MS_TR_ST,
		MS_VX_ST,
		MS_VY_ST
	} mul_sel_t;

	typedef enum logic [4:0] {
		A_NONE,
		A_LOAD_CMD,
		A_LOAD_STATE,
		A_TURN,
		A_CINIT,
		A_CSTEP,
		A_ACC_LOAD,
		A_ACC_ADD,
		A_WX,
		A_WY,
		A_DV,
		A_LPREP,
		A_SINIT,
		A_SSTEP,
		A_NUM_A,
		A_NUM_B,
		A_DSTEP,
		A_QA,
		A_QB,
		A_VSUM,
		A_VSTORE,
		A_HDG,
		A_POSX,
		A_POSY,
		A_CAPTURE
	} act_t;

	typedef struct packed {
		mul_sel_t    mul;
		act_t        act;
		logic [4:0]  idx;
		logic        lim_sel;
	} cmd_t;

	typedef struct packed {
		logic        exceed;
		logic        m_zero;
		logic [9:0]  substeps;
	} stat_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340247;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			5'd31: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/rate_limited_pose_integrator.sv */
// Rate-limited pose integrator: top level joining the sequencer and the datapath.
// Depends on rlpi_pkg, rlpi_ctrl, rlpi_dpath.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one item per transfer: kind 0 is a
//   move command run for substeps_per_move substeps, kind 1 loads the state.
//   Output channel (out_valid/out_stall) returns the full state after every item.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes register
//   cfg_index; cfg_ready is always high. Write only while the block is idle.
// Timing:
//   One item at a time. A load or a zero-substep move goes straight to the done state,
//   where the result is captured into the output register once that register is free.
//   Each substep of a move updates the turn rate, runs the CORDIC, rotates the command
//   and applies two vector limits, then updates heading and position; a limit that
//   clips adds a square root and two divides.
// Reset: registers return to their defaults, the state is zero, no result pending.
// Stall: a finished result waits in the output register; the next item is taken
//   meanwhile but its result is held back until the pending one is transferred.
`timescale 1ns / 1ps
`default_nettype none

module rate_limited_pose_integrator #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire                  kind,
	input  wire  signed [31:0]   cmd_vx,
	input  wire  signed [31:0]   cmd_vy,
	input  wire  signed [31:0]   cmd_turn_rate,
	input  wire  signed [31:0]   load_x,
	input  wire  signed [31:0]   load_y,
	input  wire  [15:0]          load_heading,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic signed [31:0]   pos_x,
	output logic signed [31:0]   pos_y,
	output logic [15:0]          heading_out,
	output logic signed [31:0]   vel_x,
	output logic signed [31:0]   vel_y,
	output logic signed [31:0]   turn_rate_out,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [2:0]           cfg_index,
	input  wire  [31:0]          cfg_data
);

	rlpi_pkg::cmd_t  cmd;
	rlpi_pkg::stat_t stat;

	rlpi_ctrl #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	rlpi_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd_vx        (cmd_vx),
		.cmd_vy        (cmd_vy),
		.cmd_turn_rate (cmd_turn_rate),
		.load_x        (load_x),
		.load_y        (load_y),
		.load_heading  (load_heading),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.heading_out   (heading_out),
		.vel_x         (vel_x),
		.vel_y         (vel_y),
		.turn_rate_out (turn_rate_out)
	);

endmodule

`default_nettype wire

/* hdl/rlpi_ctrl.sv */
// Sequencer for the pose integrator: steps the datapath through each substep.
// Depends on rlpi_pkg (cmd_t, stat_t).
`timescale 1ns / 1ps
`default_nettype none

module rlpi_ctrl #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire                 kind,
	output logic                out_valid,
	input  wire                 out_stall,
	output rlpi_pkg::cmd_t      cmd,
	input  rlpi_pkg::stat_t     stat
);

	typedef enum logic [5:0] {
		S_IDLE, S_TURN, S_CINIT, S_CSTEP,
		S_R1, S_R2, S_R3, S_R4, S_R5, S_DV,
		S_LPREP, S_SQA, S_SQB, S_SQL, S_CMP,
		S_SINIT, S_SSTEP, S_AL, S_NUMA, S_DIVA, S_QA,
		S_NUMB, S_DIVB, S_QB, S_VSUM, S_VSTORE,
		S_HM, S_HA, S_PXM, S_PXA, S_PYA, S_DONE
	} state_t;

	state_t                       state_q;
	logic [rlpi_pkg::CNT_W-1:0]   cnt_q;
	logic [9:0]                   sub_q;
	logic                         pass_q;
	logic                         out_valid_q;
	logic                         out_free;
	state_t                       lim_ret;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign lim_ret   = pass_q ? S_VSTORE : S_VSUM;

	always_comb begin
		cmd.mul     = rlpi_pkg::MS_NONE;
		cmd.act     = rlpi_pkg::A_NONE;
		cmd.idx     = cnt_q[4:0];
		cmd.lim_sel = pass_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid)
					cmd.act = kind ? rlpi_pkg::A_LOAD_STATE : rlpi_pkg::A_LOAD_CMD;
			end
			S_TURN:   cmd.act = rlpi_pkg::A_TURN;
			S_CINIT:  cmd.act = rlpi_pkg::A_CINIT;
			S_CSTEP:  cmd.act = rlpi_pkg::A_CSTEP;
			S_R1:     cmd.mul = rlpi_pkg::MS_VX_C;
			S_R2: begin
				cmd.mul = rlpi_pkg::MS_VY_S;
				cmd.act = rlpi_pkg::A_ACC_LOAD;
			end
			S_R3: begin
				cmd.mul = rlpi_pkg::MS_VX_S;
				cmd.act = rlpi_pkg::A_WX;
			end
			S_R4: begin
				cmd.mul = rlpi_pkg::MS_VY_C;
				cmd.act = rlpi_pkg::A_ACC_LOAD;
			end
			S_R5:     cmd.act = rlpi_pkg::A_WY;
			S_DV:     cmd.act = rlpi_pkg::A_DV;
			S_LPREP:  cmd.act = rlpi_pkg::A_LPREP;
			S_SQA:    cmd.mul = rlpi_pkg::MS_AA;
			S_SQB: begin
				cmd.mul = rlpi_pkg::MS_BB;
				cmd.act = rlpi_pkg::A_ACC_LOAD;
			end
			S_SQL: begin
				cmd.mul = rlpi_pkg::MS_LL;
				cmd.act = rlpi_pkg::A_ACC_ADD;
			end
			S_CMP:    cmd.act = rlpi_pkg::A_NONE;
			S_SINIT:  cmd.act = rlpi_pkg::A_SINIT;
			S_SSTEP:  cmd.act = rlpi_pkg::A_SSTEP;
			S_AL:     cmd.mul = rlpi_pkg::MS_AL;
			S_NUMA: begin
				cmd.mul = rlpi_pkg::MS_BL;
				cmd.act = rlpi_pkg::A_NUM_A;
			end
			S_DIVA:   cmd.act = rlpi_pkg::A_DSTEP;
			S_QA:     cmd.act = rlpi_pkg::A_QA;
			S_NUMB:   cmd.act = rlpi_pkg::A_NUM_B;
			S_DIVB:   cmd.act = rlpi_pkg::A_DSTEP;
			S_QB:     cmd.act = rlpi_pkg::A_QB;
			S_VSUM:   cmd.act = rlpi_pkg::A_VSUM;
			S_VSTORE: cmd.act = rlpi_pkg::A_VSTORE;
			S_HM:     cmd.mul = rlpi_pkg::MS_TR_ST;
			S_HA:     cmd.act = rlpi_pkg::A_HDG;
			S_PXM:    cmd.mul = rlpi_pkg::MS_VX_ST;
			S_PXA: begin
				cmd.mul = rlpi_pkg::MS_VY_ST;
				cmd.act = rlpi_pkg::A_POSX;
			end
			S_PYA:    cmd.act = rlpi_pkg::A_POSY;
			S_DONE: begin
				if (out_free)
					cmd.act = rlpi_pkg::A_CAPTURE;
			end
			default:  cmd.act = rlpi_pkg::A_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sub_q       <= '0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sub_q <= '0;
						if (kind || stat.substeps == 10'd0)
							state_q <= S_DONE;
						else
							state_q <= S_TURN;
					end
				end
				S_TURN: state_q <= S_CINIT;
				S_CINIT: begin
					cnt_q   <= '0;
					state_q <= S_CSTEP;
				end
				S_CSTEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == rlpi_pkg::CNT_W'(CORDIC_STAGES - 1))
						state_q <= S_R1;
				end
				S_R1: state_q <= S_R2;
				S_R2: state_q <= S_R3;
				S_R3: state_q <= S_R4;
				S_R4: state_q <= S_R5;
				S_R5: state_q <= S_DV;
				S_DV: begin
					pass_q  <= 1'b0;
					state_q <= S_LPREP;
				end
				S_LPREP: state_q <= S_SQA;
				S_SQA:   state_q <= S_SQB;
				S_SQB:   state_q <= S_SQL;
				S_SQL:   state_q <= S_CMP;
				S_CMP:   state_q <= stat.exceed ? S_SINIT : lim_ret;
				S_SINIT: begin
					cnt_q   <= '0;
					state_q <= S_SSTEP;
				end
				S_SSTEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == rlpi_pkg::CNT_W'(31))
						state_q <= S_AL;
				end
				S_AL: state_q <= stat.m_zero ? lim_ret : S_NUMA;
				S_NUMA: begin
					cnt_q   <= '0;
					state_q <= S_DIVA;
				end
				S_DIVA: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == rlpi_pkg::CNT_W'(31))
						state_q <= S_QA;
				end
				S_QA: state_q <= S_NUMB;
				S_NUMB: begin
					cnt_q   <= '0;
					state_q <= S_DIVB;
				end
				S_DIVB: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == rlpi_pkg::CNT_W'(31))
						state_q <= S_QB;
				end
				S_QB: state_q <= lim_ret;
				S_VSUM: begin
					pass_q  <= 1'b1;
					state_q <= S_LPREP;
				end
				S_VSTORE: state_q <= S_HM;
				S_HM:     state_q <= S_HA;
				S_HA:     state_q <= S_PXM;
				S_PXM:    state_q <= S_PXA;
				S_PXA:    state_q <= S_PYA;
				S_PYA: begin
					if (sub_q + 10'd1 == stat.substeps) begin
						state_q <= S_DONE;
					end else begin
						sub_q   <= sub_q + 10'd1;
						state_q <= S_TURN;
					end
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/rlpi_dpath.sv */
// Datapath of the pose integrator: state, configuration registers, shared multiplier,
// iterative CORDIC, square root and divider, and the result register.
// Depends on rlpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlpi_dpath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  rlpi_pkg::cmd_t       cmd,
	output rlpi_pkg::stat_t      stat,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [2:0]           cfg_index,
	input  wire  [31:0]          cfg_data,
	input  wire  signed [31:0]   cmd_vx,
	input  wire  signed [31:0]   cmd_vy,
	input  wire  signed [31:0]   cmd_turn_rate,
	input  wire  signed [31:0]   load_x,
	input  wire  signed [31:0]   load_y,
	input  wire  [15:0]          load_heading,
	output logic signed [31:0]   pos_x,
	output logic signed [31:0]   pos_y,
	output logic [15:0]          heading_out,
	output logic signed [31:0]   vel_x,
	output logic signed [31:0]   vel_y,
	output logic signed [31:0]   turn_rate_out
);

	// configuration
	logic [9:0]   substeps_q;
	logic [31:0]  step_time_q;
	logic [30:0]  max_turn_q;
	logic [30:0]  turn_step_q;
	logic [30:0]  max_speed_q;
	logic [30:0]  speed_step_q;

	// architectural state
	logic signed [47:0] pos_x_q;
	logic signed [47:0] pos_y_q;
	logic [31:0]        hdg_q;
	logic signed [31:0] vel_x_q;
	logic signed [31:0] vel_y_q;
	logic signed [31:0] tr_q;

	// working registers
	logic signed [31:0] cvx_q;
	logic signed [31:0] cvy_q;
	logic signed [31:0] ctr_q;
	logic signed [33:0] cx_q;
	logic signed [33:0] cy_q;
	logic signed [33:0] cz_q;
	logic               flip_q;
	logic signed [67:0] prod_q;
	logic signed [67:0] acc_q;
	logic signed [35:0] wx_q;
	logic signed [35:0] wy_q;
	logic signed [35:0] lx_q;
	logic signed [35:0] ly_q;
	logic [30:0]        a_q;
	logic [30:0]        b_q;
	logic               kpos_q;
	logic               sx_q;
	logic               sy_q;
	logic [63:0]        n_q;
	logic [63:0]        res_q;
	logic [63:0]        bit_q;
	logic [63:0]        dnum_q;
	logic [31:0]        drem_q;
	logic [31:0]        quo_q;

	logic signed [33:0] ma;
	logic signed [33:0] mb;
	logic signed [33:0] cos_c;
	logic signed [33:0] sin_c;
	logic [30:0]        lim;
	logic [31:0]        tr_mag;
	logic [31:0]        vx_mag;
	logic [31:0]        vy_mag;
	logic [35:0]        amag;
	logic [35:0]        bmag;
	logic [35:0]        omag;
	logic [2:0]         kk;
	logic [31:0]        m;
	logic [32:0]        dtrial;
	logic               dge;
	logic [63:0]        strial;
	logic [63:0]        num;
	logic signed [67:0] wsum;
	logic signed [67:0] wshift;
	logic signed [32:0] dturn;
	logic signed [32:0] trs;
	logic signed [32:0] dcl;
	logic signed [33:0] tnew;
	logic signed [33:0] mtr;
	logic signed [33:0] tcl;
	logic signed [33:0] xs;
	logic signed [33:0] ys;
	logic signed [33:0] atn;
	logic [63:0]        hm;
	logic [47:0]        pm;
	logic [31:0]        cfg_mask;

	function automatic logic signed [47:0] pos_add(input logic signed [47:0] p,
			input logic neg, input logic [47:0] d);
		logic signed [49:0] s;
		logic signed [49:0] dd;
		dd = neg ? -$signed({2'b00, d}) : $signed({2'b00, d});
		s  = $signed({{2{p[47]}}, p}) + dd;
		if (s > rlpi_pkg::POS_MAX)
			s = rlpi_pkg::POS_MAX;
		else if (s < rlpi_pkg::POS_MIN)
			s = rlpi_pkg::POS_MIN;
		return s[47:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign cfg_mask  = cfg_data;

	assign cos_c  = flip_q ? -cx_q : cx_q;
	assign sin_c  = flip_q ? -cy_q : cy_q;
	assign lim    = cmd.lim_sel ? max_speed_q : speed_step_q;
	assign tr_mag = tr_q[31] ? (~tr_q + 32'd1) : tr_q;
	assign vx_mag = vel_x_q[31] ? (~vel_x_q + 32'd1) : vel_x_q;
	assign vy_mag = vel_y_q[31] ? (~vel_y_q + 32'd1) : vel_y_q;
	assign amag   = lx_q[35] ? (~lx_q + 36'd1) : lx_q;
	assign bmag   = ly_q[35] ? (~ly_q + 36'd1) : ly_q;
	assign omag   = amag | bmag;
	assign m      = res_q[31:0];
	assign dtrial = {drem_q, dnum_q[63]};
	assign dge    = dtrial >= {1'b0, m};
	assign strial = res_q + bit_q;
	assign num    = prod_q[63:0] + {33'd0, m[31:1]};
	assign hm     = (prod_q[63:0] + 64'd8388608) >> 24;
	assign pm     = 48'((prod_q[63:0] + 64'd32768) >> 16);

	assign stat.exceed   = kpos_q || (acc_q > prod_q);
	assign stat.m_zero   = (m == 32'd0);
	assign stat.substeps = substeps_q;

	// smallest shift that brings both magnitudes below 2^31
	always_comb begin
		kk = 3'd0;
		for (int j = 5; j >= 0; j--) begin
			if ((omag >> j) < 36'h080000000)
				kk = 3'(j);
		end
	end

	always_comb begin
		dturn = $signed({ctr_q[31], ctr_q}) - $signed({tr_q[31], tr_q});
		trs   = $signed({2'b00, turn_step_q});
		if (dturn > trs)
			dcl = trs;
		else if (dturn < -trs)
			dcl = -trs;
		else
			dcl = dturn;
		tnew = $signed({{2{tr_q[31]}}, tr_q}) + $signed({dcl[32], dcl});
		mtr  = $signed({3'b000, max_turn_q});
		if (tnew > mtr)
			tcl = mtr;
		else if (tnew < -mtr)
			tcl = -mtr;
		else
			tcl = tnew;
	end

	always_comb begin
		xs  = cx_q >>> cmd.idx;
		ys  = cy_q >>> cmd.idx;
		atn = $signed({2'b00, rlpi_pkg::atan_turn(cmd.idx)});
	end

	always_comb begin
		if (cmd.act == rlpi_pkg::A_WY)
			wsum = acc_q + prod_q + 68'sd536870912;
		else
			wsum = acc_q - prod_q + 68'sd536870912;
		wshift = wsum >>> 30;
	end

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.mul)
			rlpi_pkg::MS_VX_C: begin
				ma = 34'(cvx_q);
				mb = cos_c;
			end
			rlpi_pkg::MS_VY_S: begin
				ma = 34'(cvy_q);
				mb = sin_c;
			end
			rlpi_pkg::MS_VX_S: begin
				ma = 34'(cvx_q);
				mb = sin_c;
			end
			rlpi_pkg::MS_VY_C: begin
				ma = 34'(cvy_q);
				mb = cos_c;
			end
			rlpi_pkg::MS_AA: begin
				ma = $signed({3'b000, a_q});
				mb = $signed({3'b000, a_q});
			end
			rlpi_pkg::MS_BB: begin
				ma = $signed({3'b000, b_q});
				mb = $signed({3'b000, b_q});
			end
			rlpi_pkg::MS_LL: begin
				ma = $signed({3'b000, lim});
				mb = $signed({3'b000, lim});
			end
			rlpi_pkg::MS_AL: begin
				ma = $signed({3'b000, a_q});
				mb = $signed({3'b000, lim});
			end
			rlpi_pkg::MS_BL: begin
				ma = $signed({3'b000, b_q});
				mb = $signed({3'b000, lim});
			end
			rlpi_pkg::MS_TR_ST: begin
				ma = $signed({2'b00, tr_mag});
				mb = $signed({2'b00, step_time_q});
			end
			rlpi_pkg::MS_VX_ST: begin
				ma = $signed({2'b00, vx_mag});
				mb = $signed({2'b00, step_time_q});
			end
			rlpi_pkg::MS_VY_ST: begin
				ma = $signed({2'b00, vy_mag});
				mb = $signed({2'b00, step_time_q});
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			substeps_q   <= rlpi_pkg::RST_SUBSTEPS;
			step_time_q  <= rlpi_pkg::RST_STEP_TIME;
			max_turn_q   <= rlpi_pkg::RST_MAX_TURN;
			turn_step_q  <= rlpi_pkg::RST_TURN_STEP;
			max_speed_q  <= rlpi_pkg::RST_MAX_SPEED;
			speed_step_q <= rlpi_pkg::RST_SPEED_STEP;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			hdg_q        <= '0;
			vel_x_q      <= '0;
			vel_y_q      <= '0;
			tr_q         <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					rlpi_pkg::REG_SUBSTEPS:   substeps_q   <= cfg_mask[9:0];
					rlpi_pkg::REG_STEP_TIME:  step_time_q  <= cfg_mask;
					rlpi_pkg::REG_MAX_TURN:   max_turn_q   <= cfg_mask[30:0];
					rlpi_pkg::REG_TURN_STEP:  turn_step_q  <= cfg_mask[30:0];
					rlpi_pkg::REG_MAX_SPEED:  max_speed_q  <= cfg_mask[30:0];
					rlpi_pkg::REG_SPEED_STEP: speed_step_q <= cfg_mask[30:0];
					default: ;
				endcase
			end
			unique case (cmd.act)
				rlpi_pkg::A_LOAD_STATE: begin
					vel_x_q <= cmd_vx;
					vel_y_q <= cmd_vy;
					tr_q    <= cmd_turn_rate;
					pos_x_q <= {load_x, 16'd0};
					pos_y_q <= {load_y, 16'd0};
					hdg_q   <= {load_heading, 16'd0};
				end
				rlpi_pkg::A_TURN:   tr_q <= tcl[31:0];
				rlpi_pkg::A_VSTORE: begin
					vel_x_q <= lx_q[31:0];
					vel_y_q <= ly_q[31:0];
				end
				rlpi_pkg::A_HDG: begin
					if (tr_q[31])
						hdg_q <= hdg_q - hm[31:0];
					else
						hdg_q <= hdg_q + hm[31:0];
				end
				rlpi_pkg::A_POSX: pos_x_q <= pos_add(pos_x_q, vel_x_q[31], pm);
				rlpi_pkg::A_POSY: pos_y_q <= pos_add(pos_y_q, vel_y_q[31], pm);
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.mul != rlpi_pkg::MS_NONE)
			prod_q <= ma * mb;
		unique case (cmd.act)
			rlpi_pkg::A_LOAD_CMD: begin
				cvx_q <= cmd_vx;
				cvy_q <= cmd_vy;
				ctr_q <= cmd_turn_rate;
			end
			rlpi_pkg::A_CINIT: begin
				flip_q <= (hdg_q[31:30] == 2'b01) || (hdg_q[31:30] == 2'b10);
				cz_q   <= 34'(((hdg_q[31:30] == 2'b01) || (hdg_q[31:30] == 2'b10))
					? $signed(hdg_q + 32'h80000000) : $signed(hdg_q));
				cx_q   <= rlpi_pkg::CORDIC_INIT;
				cy_q   <= '0;
			end
			rlpi_pkg::A_CSTEP: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - atn;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + atn;
				end
			end
			rlpi_pkg::A_ACC_LOAD: acc_q <= prod_q;
			rlpi_pkg::A_ACC_ADD:  acc_q <= acc_q + prod_q;
			rlpi_pkg::A_WX:       wx_q  <= wshift[35:0];
			rlpi_pkg::A_WY:       wy_q  <= wshift[35:0];
			rlpi_pkg::A_DV: begin
				lx_q <= wx_q - 36'(vel_x_q);
				ly_q <= wy_q - 36'(vel_y_q);
			end
			rlpi_pkg::A_LPREP: begin
				a_q    <= 31'(amag >> kk);
				b_q    <= 31'(bmag >> kk);
				kpos_q <= (kk != 3'd0);
				sx_q   <= lx_q[35];
				sy_q   <= ly_q[35];
			end
			rlpi_pkg::A_SINIT: begin
				n_q   <= acc_q[63:0];
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			rlpi_pkg::A_SSTEP: begin
				if (n_q >= strial) begin
					n_q   <= n_q - strial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			rlpi_pkg::A_NUM_A, rlpi_pkg::A_NUM_B: begin
				drem_q <= num[63:32];
				dnum_q <= {num[31:0], 32'd0};
				quo_q  <= '0;
			end
			rlpi_pkg::A_DSTEP: begin
				drem_q <= dge ? 32'(dtrial - {1'b0, m}) : dtrial[31:0];
				dnum_q <= dnum_q << 1;
				quo_q  <= {quo_q[30:0], dge};
			end
			rlpi_pkg::A_QA: lx_q <= sx_q ? -$signed({4'd0, quo_q}) : $signed({4'd0, quo_q});
			rlpi_pkg::A_QB: ly_q <= sy_q ? -$signed({4'd0, quo_q}) : $signed({4'd0, quo_q});
			rlpi_pkg::A_VSUM: begin
				lx_q <= 36'(vel_x_q) + lx_q;
				ly_q <= 36'(vel_y_q) + ly_q;
			end
			rlpi_pkg::A_CAPTURE: begin
				pos_x         <= pos_x_q[47:16];
				pos_y         <= pos_y_q[47:16];
				heading_out   <= hdg_q[31:16];
				vel_x         <= vel_x_q;
				vel_y         <= vel_y_q;
				turn_rate_out <= tr_q;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

/* hdl/rlpi_checker.sv */
// Port-level checks for the pose integrator, bound to the top level.
// Depends on rate_limited_pose_integrator port names.
`timescale 1ns / 1ps
`default_nettype none

module rlpi_sva (
	input wire                clk,
	input wire                arst_n,
	input wire                in_valid,
	input wire                in_stall,
	input wire                out_valid,
	input wire                out_stall,
	input wire signed [31:0]  pos_x
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pos_x))
		else $error("stalled result changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken before the first finished");

	a_result_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall && $past(in_stall))
		else $error("result appeared without a finished item");

endmodule

bind rate_limited_pose_integrator rlpi_sva u_rlpi_sva (.*);

`default_nettype wire
